// ===== rtl/wmrm_pkg.sv =====
package wmrm_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int COUNT_WIDTH  = 16;
   localparam int SUM_WIDTH    = SAMPLE_WIDTH + COUNT_WIDTH;
   localparam int SQUARE_WIDTH = 2 * SAMPLE_WIDTH + COUNT_WIDTH;
   localparam int RAD_WIDTH    = 2 * SAMPLE_WIDTH;
   localparam int RREM_WIDTH   = SAMPLE_WIDTH + 2;
   localparam int STEP_WIDTH   = $clog2(SQUARE_WIDTH);
   localparam int K            = 1024;

   localparam logic [COUNT_WIDTH-1:0] WINDOW_RESET = COUNT_WIDTH'(8 * K);

   // commands from the controller to the datapath
   typedef struct packed {
      logic accumulate;
      logic start_div;
      logic div_step;
      logic root_init;
      logic root_step;
      logic load_out;
   } wmrm_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic win_done;
      logic div_last;
      logic root_last;
   } wmrm_status_type;

endpackage

// ===== rtl/wmrm_datapath.sv =====
module wmrm_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [wmrm_pkg::SAMPLE_WIDTH-1:0]  req_sample,
   input  logic                               csr_wr_en,
   input  logic [wmrm_pkg::COUNT_WIDTH-1:0]   csr_wr_data,
   input  wmrm_pkg::wmrm_cmd_type             cmd,
   output wmrm_pkg::wmrm_status_type          status,
   output logic [wmrm_pkg::SAMPLE_WIDTH-1:0]  rsp_rms_value,
   output logic [wmrm_pkg::SAMPLE_WIDTH-1:0]  rsp_mean_value
);
   import wmrm_pkg::*;

   logic [COUNT_WIDTH-1:0]  window_ff, window_in;
   logic [SQUARE_WIDTH-1:0] sq_ff, sq_in;
   logic [SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [COUNT_WIDTH-1:0]  drem_ff, drem_in;
   logic [COUNT_WIDTH-1:0]  srem_ff, srem_in;
   logic [SAMPLE_WIDTH-1:0] root_ff, root_in;
   logic [RREM_WIDTH-1:0]   rrem_ff, rrem_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic [SAMPLE_WIDTH-1:0] rms_ff, rms_in;
   logic [SAMPLE_WIDTH-1:0] mean_ff, mean_in;

   logic [RAD_WIDTH-1:0]    sample_sq;
   logic [COUNT_WIDTH-1:0]  count_next;
   logic [COUNT_WIDTH:0]    dtmp, stmp;
   logic                    dge, sge, sum_active;
   logic [RREM_WIDTH+1:0]   rtmp, rtrial;
   logic                    rge;

   assign sample_sq  = RAD_WIDTH'(req_sample) * RAD_WIDTH'(req_sample);
   assign count_next = count_ff + 1'b1;

   assign status.win_done  = count_next >= window_ff;
   assign status.div_last  = step_ff == STEP_WIDTH'(SQUARE_WIDTH - 1);
   assign status.root_last = step_ff == STEP_WIDTH'(SAMPLE_WIDTH - 1);

   // restoring division, one quotient bit per step, quotient shifts in at the bottom
   assign dtmp = {drem_ff, sq_ff[SQUARE_WIDTH-1]};
   assign dge  = dtmp >= {1'b0, count_ff};
   assign stmp = {srem_ff, sum_ff[SUM_WIDTH-1]};
   assign sge  = stmp >= {1'b0, count_ff};
   assign sum_active = step_ff < STEP_WIDTH'(SUM_WIDTH);

   // digit recurrence square root, two radicand bits per step
   assign rtmp   = {rrem_ff, sq_ff[RAD_WIDTH-1 -: 2]};
   assign rtrial = (RREM_WIDTH+2)'({root_ff, 2'b01});
   assign rge    = rtmp >= rtrial;

   always_comb begin
      window_in = csr_wr_en ? csr_wr_data : window_ff;

      sq_in    = sq_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      drem_in  = drem_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      rrem_in  = rrem_ff;
      step_in  = step_ff;
      rms_in   = rms_ff;
      mean_in  = mean_ff;

      if (cmd.accumulate) begin
         sq_in    = sq_ff + SQUARE_WIDTH'(sample_sq);
         sum_in   = sum_ff + SUM_WIDTH'(req_sample);
         count_in = count_next;
      end
      if (cmd.start_div) begin
         drem_in = '0;
         srem_in = '0;
         step_in = '0;
      end
      if (cmd.div_step) begin
         drem_in = dge ? COUNT_WIDTH'(dtmp - {1'b0, count_ff}) : dtmp[COUNT_WIDTH-1:0];
         sq_in   = {sq_ff[SQUARE_WIDTH-2:0], dge};
         if (sum_active) begin
            srem_in = sge ? COUNT_WIDTH'(stmp - {1'b0, count_ff}) : stmp[COUNT_WIDTH-1:0];
            sum_in  = {sum_ff[SUM_WIDTH-2:0], sge};
         end
         step_in = step_ff + 1'b1;
      end
      if (cmd.root_step) begin
         rrem_in = rge ? RREM_WIDTH'(rtmp - rtrial) : RREM_WIDTH'(rtmp);
         root_in = {root_ff[SAMPLE_WIDTH-2:0], rge};
         sq_in   = {sq_ff[SQUARE_WIDTH-3:0], 2'b00};
         step_in = step_ff + 1'b1;
      end
      if (cmd.root_init) begin
         root_in = '0;
         rrem_in = '0;
         step_in = '0;
      end
      if (cmd.load_out) begin
         // empty window divisor gives zero results
         rms_in   = (count_ff == '0) ? '0 : root_ff;
         mean_in  = (count_ff == '0) ? '0 : sum_ff[SAMPLE_WIDTH-1:0];
         sq_in    = '0;
         sum_in   = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         sq_ff     <= '0;
         sum_ff    <= '0;
         count_ff  <= '0;
      end else begin
         window_ff <= window_in;
         sq_ff     <= sq_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      drem_ff <= drem_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      rrem_ff <= rrem_in;
      step_ff <= step_in;
      rms_ff  <= rms_in;
      mean_ff <= mean_in;
   end

   assign rsp_rms_value  = rms_ff;
   assign rsp_mean_value = mean_ff;

endmodule

// ===== rtl/wmrm_ctrl.sv =====
module wmrm_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  wmrm_pkg::wmrm_status_type  status,
   output wmrm_pkg::wmrm_cmd_type     cmd
);
   import wmrm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_ROOT = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.accumulate = accept;
      cmd.start_div  = accept && status.win_done;
      cmd.div_step   = state_ff == ST_DIV;
      cmd.root_init  = (state_ff == ST_DIV) && status.div_last;
      cmd.root_step  = state_ff == ST_ROOT;
      cmd.load_out   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start_div) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (status.root_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (cmd.load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_div_to_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && status.div_last |=> state_ff == ST_ROOT)
      else $error("division did not hand over to square root");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result load did not raise response valid");

   a_window_end_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |=> !req_ready && cmd.div_step)
      else $error("window end did not start the divider");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_valid_ff || rsp_ready)
      else $error("pending response overwritten");

endmodule

// ===== rtl/windowed_mean_rms_meter.sv =====
// Windowed mean and RMS meter. Unsigned 16-bit samples are taken over a valid/ready
// request channel and summed, squared and counted; when the count reaches the
// window size register (reset 8192, written through csr_wr_en/csr_wr_data at any
// edge) one response carries the truncated mean and the floor square root of the
// truncated mean of squares, and all accumulators restart. A sample that does not
// close its window leaves the meter ready for the next. The sample that closes a
// window is followed by a one-bit-per-cycle restoring divider (both divisions run
// side by side, the mean on the 32-bit sum and the mean of squares on the 48-bit
// sum of squares word), a two-bits-per-cycle square root and a response load,
// during which no request is taken. A finished response waits in its own
// register, so requests of the next window flow while it is unread; the next
// window's response load waits only if that register is still full.
module windowed_mean_rms_meter (
   input  logic                               clock,
   input  logic                               reset,
   // sample requests
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [wmrm_pkg::SAMPLE_WIDTH-1:0]  req_sample,
   // results
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [wmrm_pkg::SAMPLE_WIDTH-1:0]  rsp_rms_value,
   output logic [wmrm_pkg::SAMPLE_WIDTH-1:0]  rsp_mean_value,
   // window size register
   input  logic                               csr_wr_en,
   input  logic [wmrm_pkg::COUNT_WIDTH-1:0]   csr_wr_data
);
   import wmrm_pkg::*;

   // command and status between sequencer and arithmetic
   wmrm_cmd_type    cmd;
   wmrm_status_type status;

   // sequencer: accumulate, divide, root, load response
   wmrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // accumulators, shared-register divider and square root, response registers
   wmrm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_sample     (req_sample),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_rms_value  (rsp_rms_value),
      .rsp_mean_value (rsp_mean_value)
   );

endmodule
